// ===== sv/rrps_pkg.sv =====
package rrps_pkg;

    localparam int PROC_W = 3;
    localparam int CNT_W = 4;
    localparam int MAX_PROCS_DEF = 8;

    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QFILL_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_DISK_DONE = 2'd1;
    localparam logic [1:0] CMD_SYSCALL = 2'd2;
    localparam logic [1:0] CMD_TERMINATE = 2'd3;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_TERMINATED = 2'd3;

    localparam logic REG_SCHED_ENABLE = 1'b0;
    localparam logic REG_PROCESS_COUNT = 1'b1;

    localparam logic RESET_SCHED_ENABLE = 1'b1;
    localparam logic [CNT_W-1:0] RESET_PROCESS_COUNT = 4'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [PROC_W-1:0] process_id;
    } in_item_t;

    typedef struct packed {
        logic [PROC_W-1:0] running_process;
        logic step_grant;
        logic preempted_valid;
        logic [PROC_W-1:0] preempted_process;
        logic dispatched_valid;
        logic io_start_valid;
        logic [PROC_W-1:0] io_start_process;
        logic released_valid;
        logic [PROC_W-1:0] released_process;
        logic queue_overflow;
        logic all_terminated;
    } out_item_t;

    typedef struct packed {
        logic sched_enable;
        logic [CNT_W-1:0] process_count;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic pop;
    } dq_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } dq_stat_t;

endpackage

// ===== sv/rrps_apb.sv =====
module rrps_apb
    import rrps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic             sched_enable_reg;
    logic             sched_enable_next;
    logic [CNT_W-1:0] process_count_reg;
    logic [CNT_W-1:0] process_count_next;
    logic             wr_en;

    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        sched_enable_next = sched_enable_reg;
        process_count_next = process_count_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_SCHED_ENABLE:  sched_enable_next = pwdata[0];
                REG_PROCESS_COUNT: process_count_next = pwdata[CNT_W-1:0];
                default:           sched_enable_next = sched_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_enable_reg <= RESET_SCHED_ENABLE;
            process_count_reg <= RESET_PROCESS_COUNT;
        end
        else
        begin
            sched_enable_reg <= sched_enable_next;
            process_count_reg <= process_count_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SCHED_ENABLE:  prdata = {31'd0, sched_enable_reg};
            REG_PROCESS_COUNT: prdata = {{(32 - CNT_W){1'b0}}, process_count_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.sched_enable = sched_enable_reg;
    assign cfg.process_count = process_count_reg;

endmodule

// ===== sv/rrps_dq.sv =====
module rrps_dq
    import rrps_pkg::*;
#(
    parameter int IW = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  dq_ctrl_t      ctrl,
    input  logic [IW-1:0] push_data,
    output logic [IW-1:0] head_data,
    output dq_stat_t      stat
);

    logic [IW-1:0]      q_mem [QDEPTH];
    logic [IW-1:0]      head_data_reg;
    logic [QPTR_W-1:0]  head_reg;
    logic [QPTR_W-1:0]  head_next;
    logic [QPTR_W-1:0]  tail_reg;
    logic [QPTR_W-1:0]  tail_next;
    logic [QFILL_W-1:0] fill_reg;
    logic [QFILL_W-1:0] fill_next;
    logic               do_push;
    logic               do_pop;

    assign stat.empty = (fill_reg == '0);
    assign stat.full = (fill_reg == QFILL_W'(QDEPTH));
    assign do_push = ctrl.push && !stat.full;
    assign do_pop = ctrl.pop && !stat.empty;
    assign head_data = head_data_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            tail_next = tail_reg + QPTR_W'(1);
            fill_next = fill_reg + QFILL_W'(1);
        end
        else if (do_pop)
        begin
            head_next = head_reg + QPTR_W'(1);
            fill_next = fill_reg - QFILL_W'(1);
        end
    end

    // The head entry is kept in a register; a push into an empty queue goes
    // straight to it.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[tail_reg] <= push_data;
        end
        if (do_push && (tail_reg == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= q_mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== sv/rrps_core.sv =====
module rrps_core
    import rrps_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF,
    parameter int IW = $clog2(MAX_PROCS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_item_t      in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output out_item_t     out_item,
    output dq_ctrl_t      dq_ctrl,
    output logic [IW-1:0] dq_push_data,
    input  logic [IW-1:0] dq_head,
    input  dq_stat_t      dq_stat
);

    localparam int CW = $clog2(MAX_PROCS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_MOD = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_COMMIT = 4'd4;
    localparam logic [3:0] S_DISPATCH = 4'd5;
    localparam logic [3:0] S_ALL_START = 4'd6;
    localparam logic [3:0] S_ALL_CHK = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [1:0]  st_mem [MAX_PROCS];
    logic [MAX_PROCS-1:0] st_vld_reg;
    logic [1:0]  rd_data_reg;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    logic [1:0]  wr_data;
    logic [IW-1:0] rd_addr;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [PROC_W-1:0] pid_reg, pid_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [CW-1:0] t_reg, t_next;
    logic [CW-1:0] k_reg, k_next;
    logic [1:0]  cur_st_reg, cur_st_next;
    logic [1:0]  cand_st_reg, cand_st_next;
    logic        grant_reg, grant_next;
    logic        pre_reg, pre_next;
    logic [IW-1:0] pre_id_reg, pre_id_next;
    logic        disp_reg, disp_next;
    logic        io_reg, io_next;
    logic [IW-1:0] io_id_reg, io_id_next;
    logic        rel_reg, rel_next;
    logic [IW-1:0] rel_id_reg, rel_id_next;
    logic        ovf_reg, ovf_next;
    logic        all_reg, all_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    logic [CW-1:0] n_eff;
    logic [CW-1:0] t_inc;
    logic [CW-1:0] t_wrap;
    logic [1:0]    cs_after;
    logic          slot_free;

    always_comb
    begin
        if (cfg.process_count == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(cfg.process_count) > 32'(MAX_PROCS))
        begin
            n_eff = CW'(MAX_PROCS);
        end
        else
        begin
            n_eff = CW'(cfg.process_count);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            st_mem[wr_addr] <= wr_data;
        end
        if (st_vld_reg[rd_addr])
        begin
            rd_data_reg <= st_mem[rd_addr];
        end
        else
        begin
            rd_data_reg <= (rd_addr == '0) ? ST_RUNNING : ST_READY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            st_vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign t_inc = t_reg + CW'(1);
    assign t_wrap = (t_inc == n_reg) ? '0 : t_inc;
    assign cs_after = (dq_head == cur_reg) ? ST_READY : rd_data_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign dq_push_data = cur_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        pid_next = pid_reg;
        n_next = n_reg;
        cur_next = cur_reg;
        t_next = t_reg;
        k_next = k_reg;
        cur_st_next = cur_st_reg;
        cand_st_next = cand_st_reg;
        grant_next = grant_reg;
        pre_next = pre_reg;
        pre_id_next = pre_id_reg;
        disp_next = disp_reg;
        io_next = io_reg;
        io_id_next = io_id_reg;
        rel_next = rel_reg;
        rel_id_next = rel_id_reg;
        ovf_next = ovf_reg;
        all_next = all_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next = out_item_reg;
        wr_en = 1'b0;
        wr_addr = cur_reg;
        wr_data = ST_READY;
        rd_addr = cur_reg;
        dq_ctrl = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in_item.command;
                    pid_next = in_item.process_id;
                    n_next = n_eff;
                    grant_next = 1'b0;
                    pre_next = 1'b0;
                    pre_id_next = '0;
                    disp_next = 1'b0;
                    io_next = 1'b0;
                    io_id_next = '0;
                    rel_next = 1'b0;
                    rel_id_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_ALL_START;
                t_next = CW'(cur_reg) + CW'(1);
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (cfg.sched_enable)
                        begin
                            grant_next = (rd_data_reg == ST_RUNNING);
                            cur_st_next = rd_data_reg;
                            state_next = S_MOD;
                        end
                    end
                    CMD_DISK_DONE:
                    begin
                        if (!dq_stat.empty)
                        begin
                            dq_ctrl.pop = 1'b1;
                            wr_en = 1'b1;
                            wr_addr = dq_head;
                            wr_data = ST_READY;
                            rel_next = 1'b1;
                            rel_id_next = dq_head;
                            if (cs_after != ST_RUNNING)
                            begin
                                cur_st_next = cs_after;
                                state_next = S_MOD;
                            end
                        end
                    end
                    CMD_SYSCALL:
                    begin
                        if (rd_data_reg == ST_RUNNING)
                        begin
                            wr_en = 1'b1;
                            wr_addr = cur_reg;
                            wr_data = ST_BLOCKED;
                            dq_ctrl.push = !dq_stat.full;
                            ovf_next = dq_stat.full;
                            io_next = 1'b1;
                            io_id_next = cur_reg;
                        end
                    end
                    CMD_TERMINATE:
                    begin
                        if (32'(pid_reg) < 32'(MAX_PROCS))
                        begin
                            wr_en = 1'b1;
                            wr_addr = IW'(pid_reg);
                            wr_data = ST_TERMINATED;
                        end
                    end
                    default:
                    begin
                        state_next = S_ALL_START;
                    end
                endcase
            end

            S_MOD:
            begin
                if (t_reg >= n_reg)
                begin
                    t_next = t_reg - n_reg;
                end
                else
                begin
                    rd_addr = IW'(t_reg);
                    k_next = CW'(1);
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_data_reg == ST_READY || rd_data_reg == ST_RUNNING)
                begin
                    cand_st_next = rd_data_reg;
                    state_next = S_COMMIT;
                end
                else if (k_reg == n_reg)
                begin
                    state_next = S_ALL_START;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    t_next = t_wrap;
                    rd_addr = IW'(t_wrap);
                end
            end

            S_COMMIT:
            begin
                if (t_reg != CW'(cur_reg))
                begin
                    if (cur_st_reg == ST_RUNNING)
                    begin
                        wr_en = 1'b1;
                        wr_addr = cur_reg;
                        wr_data = ST_READY;
                        pre_next = 1'b1;
                        pre_id_next = cur_reg;
                    end
                    state_next = S_DISPATCH;
                end
                else
                begin
                    if (cand_st_reg == ST_READY)
                    begin
                        wr_en = 1'b1;
                        wr_addr = cur_reg;
                        wr_data = ST_RUNNING;
                        disp_next = 1'b1;
                    end
                    state_next = S_ALL_START;
                end
            end

            S_DISPATCH:
            begin
                wr_en = 1'b1;
                wr_addr = IW'(t_reg);
                wr_data = ST_RUNNING;
                cur_next = IW'(t_reg);
                disp_next = 1'b1;
                state_next = S_ALL_START;
            end

            S_ALL_START:
            begin
                rd_addr = '0;
                k_next = '0;
                all_next = 1'b1;
                state_next = S_ALL_CHK;
            end

            S_ALL_CHK:
            begin
                if (rd_data_reg != ST_TERMINATED)
                begin
                    all_next = 1'b0;
                end
                if (k_reg + CW'(1) == n_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    rd_addr = IW'(k_reg + CW'(1));
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next.running_process = PROC_W'(cur_reg);
                    out_item_next.step_grant = grant_reg;
                    out_item_next.preempted_valid = pre_reg;
                    out_item_next.preempted_process = PROC_W'(pre_id_reg);
                    out_item_next.dispatched_valid = disp_reg;
                    out_item_next.io_start_valid = io_reg;
                    out_item_next.io_start_process = PROC_W'(io_id_reg);
                    out_item_next.released_valid = rel_reg;
                    out_item_next.released_process = PROC_W'(rel_id_reg);
                    out_item_next.queue_overflow = ovf_reg;
                    out_item_next.all_terminated = all_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pid_reg <= pid_next;
        n_reg <= n_next;
        t_reg <= t_next;
        k_reg <= k_next;
        cur_st_reg <= cur_st_next;
        cand_st_reg <= cand_st_next;
        grant_reg <= grant_next;
        pre_reg <= pre_next;
        pre_id_reg <= pre_id_next;
        disp_reg <= disp_next;
        io_reg <= io_next;
        io_id_reg <= io_id_next;
        rel_reg <= rel_next;
        rel_id_reg <= rel_id_next;
        ovf_reg <= ovf_next;
        all_reg <= all_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

endmodule

// ===== sv/round_robin_process_scheduler_unit.sv =====
// Channel    Direction  Handshake                     Payload
// config     in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
// event      in         in_valid, in_ready            in_item (in_item_t)
// result     out        out_valid, out_ready          out_item (out_item_t)
//
// The block walks the process state memory, one entry per cycle through its single read
// port, over up to n entries (n the effective process count) to pick the next process
// and to check whether all processes are terminated; a count lowered below the running
// index adds subtraction steps in the wrap step.
// Reset is asynchronous and needs no clearing pass; the block is ready at once.
// A result waits in the output register while the next event is taken.
module round_robin_process_scheduler_unit
    import rrps_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    localparam int IW = $clog2(MAX_PROCS);

    cfg_t          cfg;
    dq_ctrl_t      dq_ctrl;
    dq_stat_t      dq_stat;
    logic [IW-1:0] dq_push_data;
    logic [IW-1:0] dq_head;

    rrps_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rrps_dq #(
        .IW (IW)
    ) u_dq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dq_ctrl),
        .push_data (dq_push_data),
        .head_data (dq_head),
        .stat      (dq_stat)
    );

    rrps_core #(
        .MAX_PROCS (MAX_PROCS),
        .IW        (IW)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (out_item),
        .dq_ctrl      (dq_ctrl),
        .dq_push_data (dq_push_data),
        .dq_head      (dq_head),
        .dq_stat      (dq_stat)
    );

endmodule

// ===== sv/rrps_chk.sv =====
module rrps_chk
    import rrps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // An event keeps the block busy, so in_ready drops after an event transfer.
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an event transfer");

    // A preemption only happens as part of a dispatch.
    a_preempt_with_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.preempted_valid |-> out_item.dispatched_valid)
        else $error("preemption reported without a dispatch");

    // An I/O start is never reported together with a release, a dispatch or a step grant.
    a_one_event_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.io_start_valid |->
            !out_item.released_valid && !out_item.dispatched_valid && !out_item.step_grant)
        else $error("I/O start mixed with another event kind");

    // Process indexes read zero when their flag is clear.
    a_idle_ids_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_item.preempted_valid || out_item.preempted_process == '0) &&
            (out_item.io_start_valid || out_item.io_start_process == '0) &&
            (out_item.released_valid || out_item.released_process == '0))
        else $error("index set while its flag is clear");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed or dropped before its transfer");

endmodule

bind round_robin_process_scheduler_unit rrps_chk u_rrps_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

// ===== dv/testbench.sv =====
module testbench;
    import rrps_pkg::*;

    typedef enum {STEP_EVENT, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t kind;
        in_item_t   ev;
        bit         typed;
        out_item_t  want;
        logic       sel;
        logic [31:0] value;
    } step_t;

    localparam int RANDOM_PHASES = 8;
    localparam int EVENTS_PER_PHASE = 160;
    localparam int SETTLE_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;

    logic [1:0]  proc_st [MAX_PROCS_DEF];
    logic [2:0]  cpu_owner;
    logic [2:0]  disk_fifo [QDEPTH];
    logic [2:0]  fifo_head;
    logic [2:0]  fifo_tail;
    int          fifo_fill;
    logic        sched_on;
    logic [3:0]  proc_limit;

    out_item_t   pending_results [$];
    step_t       directed_steps [$];
    int          errors = 0;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;

    int phase_enable [RANDOM_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};
    int phase_count [RANDOM_PHASES] = '{8, 3, 15, 8, 1, 0, 5, 8};
    int mode_snd [4] = '{0, 48, 0, 11};
    int mode_rcv [4] = '{0, 0, 48, 11};

    round_robin_process_scheduler_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    function automatic int active_procs();
        int n;
        n = int'(proc_limit);
        if (n < 1)
            n = 1;
        if (n > MAX_PROCS_DEF)
            n = MAX_PROCS_DEF;
        return n;
    endfunction

    function automatic void round_robin_pick(inout out_item_t r);
        int n;
        int i;
        int t;
        int cand;
        bit found;
        n = active_procs();
        cand = 0;
        found = 1'b0;
        for (i = 1; i <= n; i++)
        begin
            t = (int'(cpu_owner) + i) % n;
            if (!found && (proc_st[t] == ST_READY || proc_st[t] == ST_RUNNING))
            begin
                cand = t;
                found = 1'b1;
            end
        end
        if (!found)
            return;
        if (cand != int'(cpu_owner))
        begin
            if (proc_st[cpu_owner] == ST_RUNNING)
            begin
                proc_st[cpu_owner] = ST_READY;
                r.preempted_valid = 1'b1;
                r.preempted_process = cpu_owner;
            end
            cpu_owner = 3'(cand);
            proc_st[cand] = ST_RUNNING;
            r.dispatched_valid = 1'b1;
        end
        else if (proc_st[cand] == ST_READY)
        begin
            proc_st[cand] = ST_RUNNING;
            r.dispatched_valid = 1'b1;
        end
    endfunction

    function automatic out_item_t schedule_event(in_item_t ev);
        out_item_t r;
        logic [2:0] p;
        int i;
        r = '0;
        case (ev.command)
            CMD_TICK:
            begin
                if (sched_on)
                begin
                    if (proc_st[cpu_owner] == ST_RUNNING)
                        r.step_grant = 1'b1;
                    round_robin_pick(r);
                end
            end
            CMD_DISK_DONE:
            begin
                if (fifo_fill > 0)
                begin
                    p = disk_fifo[fifo_head];
                    fifo_head = fifo_head + 3'd1;
                    fifo_fill--;
                    proc_st[p] = ST_READY;
                    r.released_valid = 1'b1;
                    r.released_process = p;
                    if (proc_st[cpu_owner] != ST_RUNNING)
                        round_robin_pick(r);
                end
            end
            CMD_SYSCALL:
            begin
                if (proc_st[cpu_owner] == ST_RUNNING)
                begin
                    proc_st[cpu_owner] = ST_BLOCKED;
                    if (fifo_fill >= QDEPTH)
                        r.queue_overflow = 1'b1;
                    else
                    begin
                        disk_fifo[fifo_tail] = cpu_owner;
                        fifo_tail = fifo_tail + 3'd1;
                        fifo_fill++;
                    end
                    r.io_start_valid = 1'b1;
                    r.io_start_process = cpu_owner;
                end
            end
            default:
                proc_st[ev.process_id] = ST_TERMINATED;
        endcase
        r.all_terminated = 1'b1;
        for (i = 0; i < active_procs(); i++)
            if (proc_st[i] != ST_TERMINATED)
                r.all_terminated = 1'b0;
        r.running_process = cpu_owner;
        return r;
    endfunction

    function automatic out_item_t typed_res(int running, int grant, int pre, int disp,
                                            int io, int rel, int all);
        out_item_t r;
        r = '0;
        r.running_process = 3'(running);
        r.step_grant = 1'(grant);
        r.dispatched_valid = 1'(disp);
        r.all_terminated = 1'(all);
        if (pre >= 0)
        begin
            r.preempted_valid = 1'b1;
            r.preempted_process = 3'(pre);
        end
        if (io >= 0)
        begin
            r.io_start_valid = 1'b1;
            r.io_start_process = 3'(io);
        end
        if (rel >= 0)
        begin
            r.released_valid = 1'b1;
            r.released_process = 3'(rel);
        end
        return r;
    endfunction

    function automatic void add_event(logic [1:0] cmd, logic [2:0] pid);
        step_t s;
        s.kind = STEP_EVENT;
        s.ev.command = cmd;
        s.ev.process_id = pid;
        s.typed = 1'b0;
        s.want = '0;
        s.sel = REG_SCHED_ENABLE;
        s.value = '0;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_typed(logic [1:0] cmd, logic [2:0] pid, out_item_t want);
        add_event(cmd, pid);
        directed_steps[$].typed = 1'b1;
        directed_steps[$].want = want;
    endfunction

    function automatic void add_write(logic sel, logic [31:0] value);
        step_t s;
        s.kind = STEP_WRITE;
        s.ev = '0;
        s.typed = 1'b0;
        s.want = '0;
        s.sel = sel;
        s.value = value;
        directed_steps.push_back(s);
    endfunction

    function automatic in_item_t random_event();
        in_item_t ev;
        int roll;
        roll = $urandom_range(99);
        ev.process_id = 3'($urandom_range(7));
        if (roll < 42)
            ev.command = CMD_TICK;
        else if (roll < 67)
            ev.command = CMD_SYSCALL;
        else if (roll < 95)
            ev.command = CMD_DISK_DONE;
        else
        begin
            ev.command = CMD_TERMINATE;
            if (fifo_fill > 0 && $urandom_range(3) != 0)
                ev.process_id = disk_fifo[(fifo_head + $urandom_range(fifo_fill - 1)) % QDEPTH];
            else if (active_procs() < MAX_PROCS_DEF && $urandom_range(4) != 0)
                ev.process_id = 3'($urandom_range(MAX_PROCS_DEF - 1, active_procs()));
        end
        return ev;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result transfer with no result outstanding");
            return;
        end
        want = pending_results.pop_front();
        check_field("running_process", 32'(got.running_process),
                    32'(want.running_process));
        check_field("step_grant", 32'(got.step_grant), 32'(want.step_grant));
        check_field("preempted_valid", 32'(got.preempted_valid),
                    32'(want.preempted_valid));
        check_field("preempted_process", 32'(got.preempted_process),
                    32'(want.preempted_process));
        check_field("dispatched_valid", 32'(got.dispatched_valid),
                    32'(want.dispatched_valid));
        check_field("io_start_valid", 32'(got.io_start_valid),
                    32'(want.io_start_valid));
        check_field("io_start_process", 32'(got.io_start_process),
                    32'(want.io_start_process));
        check_field("released_valid", 32'(got.released_valid),
                    32'(want.released_valid));
        check_field("released_process", 32'(got.released_process),
                    32'(want.released_process));
        check_field("queue_overflow", 32'(got.queue_overflow),
                    32'(want.queue_overflow));
        check_field("all_terminated", 32'(got.all_terminated),
                    32'(want.all_terminated));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(out_item);
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    task automatic send_event(in_item_t ev, bit typed, out_item_t want);
        out_item_t predicted;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= ev;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = schedule_event(ev);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic sel, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_SCHED_ENABLE)
            sched_on = value[0];
        else
            proc_limit = value[CNT_W-1:0];
        @(posedge clk);
    endtask

    initial
    begin
        int i;
        int ph;
        for (i = 0; i < MAX_PROCS_DEF; i++)
            proc_st[i] = ST_READY;
        proc_st[0] = ST_RUNNING;
        cpu_owner = '0;
        for (i = 0; i < QDEPTH; i++)
            disk_fifo[i] = '0;
        fifo_head = '0;
        fifo_tail = '0;
        fifo_fill = 0;
        sched_on = RESET_SCHED_ENABLE;
        proc_limit = RESET_PROCESS_COUNT;

        add_typed(CMD_DISK_DONE, 3'd0, typed_res(0, 0, -1, 0, -1, -1, 0));
        add_typed(CMD_TICK, 3'd7, typed_res(1, 1, 0, 1, -1, -1, 0));
        add_typed(CMD_SYSCALL, 3'd0, typed_res(1, 0, -1, 0, 1, -1, 0));
        add_typed(CMD_SYSCALL, 3'd5, typed_res(1, 0, -1, 0, -1, -1, 0));
        add_typed(CMD_TICK, 3'd0, typed_res(2, 0, -1, 1, -1, -1, 0));
        add_typed(CMD_DISK_DONE, 3'd2, typed_res(2, 0, -1, 0, -1, 1, 0));
        add_typed(CMD_TERMINATE, 3'd7, typed_res(2, 0, -1, 0, -1, -1, 0));
        add_typed(CMD_TERMINATE, 3'd0, typed_res(2, 0, -1, 0, -1, -1, 0));
        add_event(CMD_TICK, 3'd3);
        add_event(CMD_SYSCALL, 3'd6);
        add_event(CMD_TERMINATE, 3'd1);
        add_event(CMD_TERMINATE, 3'd2);
        add_event(CMD_TICK, 3'd4);
        add_event(CMD_DISK_DONE, 3'd1);
        add_write(REG_SCHED_ENABLE, 32'd0);
        add_event(CMD_TICK, 3'd7);
        add_write(REG_SCHED_ENABLE, 32'd1);
        add_write(REG_PROCESS_COUNT, 32'd15);
        add_event(CMD_TICK, 3'd0);
        add_event(CMD_TICK, 3'd5);
        add_event(CMD_TICK, 3'd2);
        add_write(REG_PROCESS_COUNT, 32'd0);
        add_event(CMD_TICK, 3'd1);
        add_event(CMD_SYSCALL, 3'd7);
        add_event(CMD_DISK_DONE, 3'd3);
        add_write(REG_PROCESS_COUNT, 32'd8);
        add_event(CMD_TICK, 3'd6);
        add_write(REG_PROCESS_COUNT, 32'd2);
        add_event(CMD_TICK, 3'd4);
        add_event(CMD_TERMINATE, 3'd6);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_WRITE)
            begin
                settle();
                write_reg(directed_steps[i].sel, directed_steps[i].value);
            end
            else
                send_event(directed_steps[i].ev, directed_steps[i].typed,
                           directed_steps[i].want);
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            write_reg(REG_SCHED_ENABLE, phase_enable[ph]);
            write_reg(REG_PROCESS_COUNT, phase_count[ph]);
            snd_idle_pct = mode_snd[ph % 4];
            rcv_stall_pct = mode_rcv[ph % 4];
            repeat (EVENTS_PER_PHASE) send_event(random_event(), 1'b0, '0);
        end

        settle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rrps_pkg.sv
sv/rrps_apb.sv
sv/rrps_dq.sv
sv/rrps_core.sv
sv/round_robin_process_scheduler_unit.sv
sv/rrps_chk.sv
dv/testbench.sv
